// ===== rtl/hsv_pkg.sv =====
// Shared types and fixed constants for the RGB to HSV converter.
// No dependencies; imported by every module of the block.
package hsv_pkg;

  // Width of each channel input port
  localparam int CH_IN_W = 8;

  // Result widths
  localparam int HUE_W = 12;
  localparam int PCT_W = 10;

  // Quotient bits per divider; covers hue up to 4095 before wrap
  localparam int QUO_W = 12;

  // Doubled scale factors for round-to-nearest (2*num + den) / (2*den)
  localparam int PCT_X2 = 2000;
  localparam int HUE_X2 = 1200;

  localparam logic [HUE_W-1:0] HUE_FULL = 12'd3600;
  localparam logic [PCT_W-1:0] PCT_FULL = 10'd1000;

  // Special-case flags that ride alongside the dividers
  typedef struct packed {
    logic grey;   // spread is zero: hue forced to zero
    logic black;  // largest channel is zero: saturation forced to zero
  } flag_t;

endpackage

// ===== rtl/rgb_to_hsv_converter.sv =====
// RGB to HSV converter: one pixel in per clock, one HSV result per pixel.
// Each pixel passes prep stages A and B, the divider stages and the output
// register before it shows on done. Throughput: one pixel per cycle.
// Most of the depth comes from the 12 one-bit stages of the hue and saturation dividers.
// busy stays low; done cannot be held off. rst clears all valid bits.
module rgb_to_hsv_converter
  import hsv_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CH_IN_W-1:0] red_in,
  input  logic [CH_IN_W-1:0] green_in,
  input  logic [CH_IN_W-1:0] blue_in,
  output logic               done,
  output logic [HUE_W-1:0]   hue_out,
  output logic [PCT_W-1:0]   sat_out,
  output logic [PCT_W-1:0]   val_out
);

  localparam int NUM_W = CHANNEL_BITS + 13;
  localparam int DEN_W = CHANNEL_BITS + 1;

  // Value divides by the constant 2*full scale: multiply by its rounded-up
  // reciprocal. The shift keeps the product error below one quotient step.
  localparam int VAL_SHIFT = 2 * CHANNEL_BITS + 12;
  localparam int RCP_W     = CHANNEL_BITS + 12;
  localparam int PROD_W    = NUM_W + RCP_W;
  localparam logic [63:0] VAL_DIV = ((64'd1 << CHANNEL_BITS) - 64'd1) << 1;
  localparam logic [RCP_W-1:0] VAL_RECIP =
    RCP_W'(((64'd1 << VAL_SHIFT) + VAL_DIV - 64'd1) / VAL_DIV);

  logic             pre_vld;
  flag_t            pre_flags;
  logic [NUM_W-1:0] val_num, sat_num, hue_num;
  logic [DEN_W-1:0] sat_den, hue_den;

  logic             sat_vld, hue_vld;
  logic [QUO_W-1:0] sat_q, hue_q;

  // Value path: one product stage, then a delay line matched to the dividers
  logic [PROD_W-1:0] val_prod;
  logic [PCT_W-1:0]  val_pipe [QUO_W-1];

  // Flags for grey and black pixels ride a delay line matched to the dividers
  flag_t            flag_pipe [QUO_W];

  // Every stage advances each cycle, so a new transfer is always taken
  assign busy = 1'b0;

  // Sort channels, form the hue numerator, scale the dividends
  hsv_prep #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .vld_in    (start),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .vld_out   (pre_vld),
    .flags_out (pre_flags),
    .val_num   (val_num),
    .sat_num   (sat_num),
    .sat_den   (sat_den),
    .hue_num   (hue_num),
    .hue_den   (hue_den)
  );

  // Two matched dividers, both with the same depth so results line up
  hsv_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(QUO_W)) u_div_sat (
    .clk (clk), .rst (rst), .vld_in (pre_vld), .num_in (sat_num), .den_in (sat_den),
    .vld_out (sat_vld), .quo_out (sat_q)
  );

  hsv_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(QUO_W)) u_div_hue (
    .clk (clk), .rst (rst), .vld_in (pre_vld), .num_in (hue_num), .den_in (hue_den),
    .vld_out (hue_vld), .quo_out (hue_q)
  );

  always_ff @(posedge clk) begin
    flag_pipe[0] <= pre_flags;
    for (int i = 1; i < QUO_W; i++) begin
      flag_pipe[i] <= flag_pipe[i-1];
    end
  end

  // Multiply once, take the quotient bits, then hold pace with the dividers
  always_ff @(posedge clk) begin
    val_prod    <= PROD_W'(val_num) * PROD_W'(VAL_RECIP);
    val_pipe[0] <= val_prod[VAL_SHIFT +: PCT_W];
    for (int i = 1; i < QUO_W - 1; i++) begin
      val_pipe[i] <= val_pipe[i-1];
    end
  end

  // Output stage: wrap a full turn to zero, override the grey and black cases
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= hue_vld;
    end
    if (flag_pipe[QUO_W-1].grey) begin
      hue_out <= '0;
    end else if (hue_q >= HUE_FULL) begin
      hue_out <= hue_q - HUE_FULL;
    end else begin
      hue_out <= hue_q;
    end
    // A zero divisor leaves an all-ones quotient; drop it for black pixels
    sat_out <= flag_pipe[QUO_W-1].black ? '0 : sat_q[PCT_W-1:0];
    val_out <= val_pipe[QUO_W-2];
  end

`ifndef ASSERT_OFF
  a_div_align : assert property (@(posedge clk) disable iff (rst)
    (hue_vld == sat_vld))
    else $error("divider valid bits out of step");

  a_hue_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (hue_out < HUE_FULL))
    else $error("hue result not wrapped below a full turn");

  a_pct_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (sat_out <= PCT_FULL) && (val_out <= PCT_FULL))
    else $error("saturation or value above full scale");

  a_done_follows : assert property (@(posedge clk) disable iff (rst)
    hue_vld |=> done)
    else $error("divider result not presented");
`endif

endmodule

// ===== rtl/hsv_prep.sv =====
// Front end of the converter: channel sort, hue sector numerator, scaled dividends.
// Depends on hsv_pkg.
module hsv_prep
  import hsv_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       vld_in,
  input  logic [CH_IN_W-1:0]         red_in,
  input  logic [CH_IN_W-1:0]         green_in,
  input  logic [CH_IN_W-1:0]         blue_in,
  output logic                       vld_out,
  output flag_t                      flags_out,
  output logic [CHANNEL_BITS+12:0]   val_num,
  output logic [CHANNEL_BITS+12:0]   sat_num,
  output logic [CHANNEL_BITS:0]      sat_den,
  output logic [CHANNEL_BITS+12:0]   hue_num,
  output logic [CHANNEL_BITS:0]      hue_den
);

  localparam int CB    = CHANNEL_BITS;
  localparam int USE_W = (CB < CH_IN_W) ? CB : CH_IN_W;
  localparam int HN_W  = CB + 3;
  localparam int NUM_W = CB + 13;
  localparam logic [NUM_W-1:0] FS     = NUM_W'((64'd1 << CB) - 64'd1);

  logic [CB-1:0]   r, g, b;
  logic [CB-1:0]   mx, mn, d;
  logic [HN_W-1:0] hn;

  // stage A registers
  logic            vld_a;
  logic [CB-1:0]   mx_a, d_a;
  logic [HN_W-1:0] hn_a;
  flag_t           flags_a;

  always_comb begin
    r = CB'(red_in[USE_W-1:0]);
    g = CB'(green_in[USE_W-1:0]);
    b = CB'(blue_in[USE_W-1:0]);
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    d = mx - mn;
    // hue in sixths of a turn times the spread, already wrapped non-negative
    if (r == mx) begin
      if (g >= b) hn = HN_W'(g - b);
      else        hn = (HN_W'(d) << 2) + (HN_W'(d) << 1) - HN_W'(b - g);
    end else if (g == mx) begin
      hn = (HN_W'(d) << 1) + HN_W'(b) - HN_W'(r);
    end else begin
      hn = (HN_W'(d) << 2) + HN_W'(r) - HN_W'(g);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else begin
      vld_a <= vld_in;
    end
    mx_a          <= mx;
    d_a           <= d;
    hn_a          <= hn;
    flags_a.grey  <= (d == '0);
    flags_a.black <= (mx == '0);
  end

  // stage B: dividends 2*num*scale + den, divisors 2*den
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_a;
    end
    flags_out <= flags_a;
    val_num   <= NUM_W'(mx_a) * NUM_W'(PCT_X2) + FS;
    sat_num   <= NUM_W'(d_a) * NUM_W'(PCT_X2) + NUM_W'(mx_a);
    sat_den   <= {mx_a, 1'b0};
    hue_num   <= NUM_W'(hn_a) * NUM_W'(HUE_X2) + NUM_W'(d_a);
    hue_den   <= {d_a, 1'b0};
  end

endmodule

// ===== rtl/hsv_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, MSB first.
// Depends on hsv_pkg (imported for house consistency of widths).
module hsv_div
  import hsv_pkg::*;
#(
  parameter int NUM_W = 21,
  parameter int DEN_W = 9,
  parameter int Q_W   = QUO_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             vld_in,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  output logic             vld_out,
  output logic [Q_W-1:0]   quo_out
);

  // Register outputs of each stage
  logic             vld_s [Q_W];
  logic [Q_W-1:0]   quo_s [Q_W];
  logic [NUM_W-1:0] rem_s [Q_W-1];
  logic [DEN_W-1:0] den_s [Q_W-1];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic             vld_i;
    logic [Q_W-1:0]   quo_i;
    logic [NUM_W-1:0] rem_i;
    logic [DEN_W-1:0] den_i;
    logic [NUM_W-1:0] dsh;
    logic             take;

    if (k == 0) begin : g_head
      assign vld_i = vld_in;
      assign quo_i = '0;
      assign rem_i = num_in;
      assign den_i = den_in;
    end else begin : g_link
      assign vld_i = vld_s[k-1];
      assign quo_i = quo_s[k-1];
      assign rem_i = rem_s[k-1];
      assign den_i = den_s[k-1];
    end

    always_comb begin
      dsh  = NUM_W'(den_i) << (Q_W - 1 - k);
      take = (rem_i >= dsh);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k] <= 1'b0;
      end else begin
        vld_s[k] <= vld_i;
      end
      quo_s[k] <= {quo_i[Q_W-2:0], take};
    end

    if (k < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_s[k] <= take ? (rem_i - dsh) : rem_i;
        den_s[k] <= den_i;
      end
    end
  end

  assign vld_out = vld_s[Q_W-1];
  assign quo_out = quo_s[Q_W-1];

endmodule

// ===== tb/sv/hsv_result_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the RGB to HSV converter: predicts each pixel's HSV result.
// Compares that result with the converter's done stream.
// Depends on hsv_pkg for the port widths.
module hsv_result_checker
  import hsv_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [CH_IN_W-1:0] red_in,
  input  logic [CH_IN_W-1:0] green_in,
  input  logic [CH_IN_W-1:0] blue_in,
  input  logic               done,
  input  logic [HUE_W-1:0]   hue_out,
  input  logic [PCT_W-1:0]   sat_out,
  input  logic [PCT_W-1:0]   val_out,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
  } hsv_t;

  hsv_t pending_hsv[$];

  // Exact integer conversion; every quotient rounds to nearest, ties up.
  function automatic hsv_t rgb2hsv_fixed(input logic [CH_IN_W-1:0] r_raw,
                                         input logic [CH_IN_W-1:0] g_raw,
                                         input logic [CH_IN_W-1:0] b_raw);
    int   fs, r, g, b, mx, mn, d, num, hue;
    hsv_t res;
    fs = (1 << CHANNEL_BITS) - 1;
    r = int'(r_raw) & fs;
    g = int'(g_raw) & fs;
    b = int'(b_raw) & fs;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    d = mx - mn;
    res.val = PCT_W'((2 * mx * 1000 + fs) / (2 * fs));
    res.sat = (mx == 0) ? '0 : PCT_W'((2 * d * 1000 + mx) / (2 * mx));
    if (d == 0) begin
      hue = 0;
    end else begin
      // Sector offset in spreads, first matching channel wins ties
      if (r == mx) num = g - b;
      else if (g == mx) num = 2 * d + (b - r);
      else num = 4 * d + (r - g);
      if (num < 0) num += 6 * d;
      hue = (2 * 600 * num + d) / (2 * d);
      if (hue >= 3600) hue -= 3600;
    end
    res.hue = HUE_W'(hue);
    return res;
  endfunction

  always @(posedge clk) begin
    hsv_t want;
    if (rst) begin
      fail_count = 0;
    end else begin
      if (start && !busy)
        pending_hsv.push_back(rgb2hsv_fixed(red_in, green_in, blue_in));
      if (done) begin
        if (pending_hsv.size() == 0) begin
          $error("done with no pixel outstanding: hue %0d sat %0d val %0d",
                 hue_out, sat_out, val_out);
          fail_count++;
        end else begin
          want = pending_hsv.pop_front();
          if (hue_out !== want.hue) begin
            $error("hue_out: expected %0d, got %0d", want.hue, hue_out);
            fail_count++;
          end
          if (sat_out !== want.sat) begin
            $error("sat_out: expected %0d, got %0d", want.sat, sat_out);
            fail_count++;
          end
          if (val_out !== want.val) begin
            $error("val_out: expected %0d, got %0d", want.val, val_out);
            fail_count++;
          end
        end
      end
    end
    pending = pending_hsv.size();
  end

endmodule

// ===== tb/sv/tb_rgb_to_hsv_converter.sv =====
`timescale 1ns / 100ps
// Top of the RGB to HSV converter testbench: clock, reset, pixel stimulus, verdict.
// Depends on hsv_pkg, rgb_to_hsv_converter and hsv_result_checker.
module tb_rgb_to_hsv_converter;
  import hsv_pkg::*;

  // Run length: directed corners, then random pixels; the tail runs gap-free.
  localparam int RANDOM_PIXELS = 1330;
  localparam int GAP_FREE_TAIL = 250;
  // Pipeline depth plus margin, waited out once the scoreboard drains
  localparam int DRAIN_CYCLES  = 40;
  // Slowest run is 1354 pixels, each with its longest idle gap; allow far more than that
  localparam int CYCLE_LIMIT   = 200000;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [CH_IN_W-1:0] red_in;
  logic [CH_IN_W-1:0] green_in;
  logic [CH_IN_W-1:0] blue_in;
  logic               done;
  logic [HUE_W-1:0]   hue_out;
  logic [PCT_W-1:0]   sat_out;
  logic [PCT_W-1:0]   val_out;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;

  // Corner pixels as 0xRRGGBB: black, white, greys, primaries, secondaries
  // (two-way ties between the largest channels), a red-sector pixel whose hue
  // goes negative before the wrap, unit spreads, and alternating bit patterns.
  logic [23:0] corner_px [0:23] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'h010000,
    24'h000100, 24'h000001, 24'hFFFEFE, 24'hFEFFFF,
    24'h7F8081, 24'h80FF7F, 24'h123456, 24'hABCDEF,
    24'h55AA00, 24'h0180FF, 24'hAA55AA, 24'h55AA55
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_to_hsv_converter uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .done     (done),
    .hue_out  (hue_out),
    .sat_out  (sat_out),
    .val_out  (val_out)
  );

  hsv_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .done       (done),
    .hue_out    (hue_out),
    .sat_out    (sat_out),
    .val_out    (val_out),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: stop a hung run with a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one pixel and hold it until the converter takes the transfer.
  // Call right after a rising edge; returns at the edge that accepted it.
  task automatic send_pixel(input logic [CH_IN_W-1:0] r,
                            input logic [CH_IN_W-1:0] g,
                            input logic [CH_IN_W-1:0] b);
    start    <= 1'b1;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for an idle gap of length n; scramble the channel ports meanwhile so
  // nothing is taken from them while start is low.
  task automatic idle_gap(input int n);
    start    <= 1'b0;
    red_in   <= CH_IN_W'($urandom);
    green_in <= CH_IN_W'($urandom);
    blue_in  <= CH_IN_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  initial begin
    logic [CH_IN_W-1:0] r, g, b, base;
    int                 gap_odds;
    int                 i;

    // Hold reset with every input at a known level
    rst      = 1'b1;
    start    = 1'b0;
    red_in   = '0;
    green_in = '0;
    blue_in  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners, back to back
    for (i = 0; i < 24; i++)
      send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);

    gap_odds = 0;
    for (i = 0; i < RANDOM_PIXELS; i++) begin
      // Pick the pixel shape: plain random, tied channels, grey,
      // channels near the rails, or a small spread around a random level
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          r = CH_IN_W'($urandom);
          g = CH_IN_W'($urandom);
          b = CH_IN_W'($urandom);
        end
        4, 5: begin
          r = CH_IN_W'($urandom);
          g = CH_IN_W'($urandom);
          case ($urandom_range(0, 2))
            0:       b = r;
            1:       b = g;
            default: begin
              b = g;
              g = r;
              r = CH_IN_W'($urandom);
            end
          endcase
        end
        6: begin
          r = CH_IN_W'($urandom);
          g = r;
          b = r;
        end
        7, 8: begin
          r = $urandom_range(0, 1) ? CH_IN_W'($urandom_range(0, 1))
                                   : CH_IN_W'($urandom_range(254, 255));
          g = $urandom_range(0, 1) ? CH_IN_W'($urandom_range(0, 1))
                                   : CH_IN_W'($urandom_range(254, 255));
          b = $urandom_range(0, 1) ? CH_IN_W'($urandom_range(0, 1))
                                   : CH_IN_W'($urandom_range(254, 255));
        end
        default: begin
          base = CH_IN_W'($urandom_range(0, 252));
          r = base + CH_IN_W'($urandom_range(0, 3));
          g = base + CH_IN_W'($urandom_range(0, 3));
          b = base + CH_IN_W'($urandom_range(0, 3));
        end
      endcase

      // Re-pick the gap density every 50 pixels, so gap-free stretches
      // alternate with sparse and dense idling; the tail has no gaps.
      if (i % 50 == 0) gap_odds = $urandom_range(0, 2);
      if (i >= RANDOM_PIXELS - GAP_FREE_TAIL) gap_odds = 0;
      if (gap_odds != 0 && $urandom_range(0, 3) < gap_odds)
        idle_gap($urandom_range(1, 5));

      send_pixel(r, g, b);
    end

    // Release the input and let every outstanding result come back
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== rgb_to_hsv_converter.f =====
rtl/hsv_pkg.sv
rtl/hsv_prep.sv
rtl/hsv_div.sv
rtl/rgb_to_hsv_converter.sv
tb/sv/hsv_result_checker.sv
tb/sv/tb_rgb_to_hsv_converter.sv
